FILE: rtl/psm_pkg.sv
// Types, constants and trie ROM for the postcode shape matcher.
package psm_pkg;

  localparam int CpW              = 21;
  localparam int NodeW            = 7;
  localparam int RomUsed          = 104;
  localparam int TrieNodesDefault = 128;

  localparam logic [CpW-1:0] CpDigitLo = 21'h000030;
  localparam logic [CpW-1:0] CpDigitHi = 21'h000039;
  localparam logic [CpW-1:0] CpUpperLo = 21'h000041;
  localparam logic [CpW-1:0] CpUpperHi = 21'h00005A;
  localparam logic [CpW-1:0] CpLowerLo = 21'h000061;
  localparam logic [CpW-1:0] CpLowerHi = 21'h00007A;
  localparam logic [CpW-1:0] CpSpace   = 21'h000020;
  localparam logic [CpW-1:0] CpMark    = 21'h003012;

  localparam logic [NodeW-1:0] RootNode = '0;

  typedef enum logic [2:0] {
    ClsN    = 3'd0,
    ClsA    = 3'd1,
    ClsSp   = 3'd2,
    ClsMark = 3'd3,
    ClsNone = 3'd4
  } cls_e;

  typedef struct packed {
    logic             dead;
    logic [NodeW-1:0] node;
  } walk_t;

  // next node per class {n, a, space, mark}; zero marks a missing move
  localparam logic [NodeW-1:0] TrieNext [RomUsed][4] = '{
    '{64, 1, 0, 95}, '{36, 2, 0, 0}, '{15, 9, 3, 0}, '{4, 0, 0, 0},
    '{5, 0, 0, 0}, '{6, 0, 0, 0}, '{7, 0, 0, 0}, '{8, 0, 0, 0},
    '{0, 0, 0, 0}, '{0, 0, 10, 0}, '{11, 0, 0, 0}, '{12, 0, 0, 0},
    '{13, 0, 0, 0}, '{14, 0, 0, 0}, '{0, 0, 0, 0}, '{25, 20, 16, 0},
    '{17, 0, 0, 0}, '{0, 18, 0, 0}, '{0, 19, 0, 0}, '{0, 0, 0, 0},
    '{0, 0, 21, 0}, '{22, 0, 0, 0}, '{0, 23, 0, 0}, '{0, 24, 0, 0},
    '{0, 0, 0, 0}, '{32, 30, 26, 0}, '{27, 0, 0, 0}, '{0, 28, 0, 0},
    '{0, 29, 0, 0}, '{0, 0, 0, 0}, '{0, 31, 0, 0}, '{0, 0, 0, 0},
    '{35, 33, 0, 0}, '{0, 34, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0},
    '{50, 41, 37, 0}, '{38, 0, 0, 0}, '{0, 39, 0, 0}, '{0, 40, 0, 0},
    '{0, 0, 0, 0}, '{47, 0, 42, 0}, '{43, 0, 0, 0}, '{0, 44, 0, 0},
    '{46, 45, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 48, 0, 0},
    '{49, 0, 0, 0}, '{0, 0, 0, 0}, '{59, 0, 51, 0}, '{56, 52, 0, 0},
    '{0, 53, 0, 0}, '{54, 0, 0, 0}, '{55, 0, 0, 0}, '{0, 0, 0, 0},
    '{0, 57, 0, 0}, '{0, 58, 0, 0}, '{0, 0, 0, 0}, '{60, 0, 0, 0},
    '{0, 61, 0, 0}, '{0, 62, 0, 0}, '{0, 63, 0, 0}, '{0, 0, 0, 0},
    '{65, 0, 0, 0}, '{70, 0, 66, 0}, '{67, 0, 0, 0}, '{68, 0, 0, 0},
    '{69, 0, 0, 0}, '{0, 0, 0, 0}, '{76, 0, 71, 0}, '{72, 0, 0, 0},
    '{73, 0, 0, 0}, '{74, 0, 0, 0}, '{75, 0, 0, 0}, '{0, 0, 0, 0},
    '{85, 83, 77, 0}, '{80, 78, 0, 0}, '{0, 79, 0, 0}, '{0, 0, 0, 0},
    '{81, 0, 0, 0}, '{82, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 84, 0, 0},
    '{0, 0, 0, 0}, '{92, 0, 86, 0}, '{87, 0, 0, 0}, '{88, 0, 0, 0},
    '{89, 0, 0, 0}, '{90, 0, 0, 0}, '{91, 0, 0, 0}, '{0, 0, 0, 0},
    '{93, 0, 0, 0}, '{94, 0, 0, 0}, '{0, 0, 0, 0}, '{96, 0, 0, 0},
    '{97, 0, 0, 0}, '{98, 0, 0, 0}, '{0, 0, 99, 0}, '{100, 0, 0, 0},
    '{101, 0, 0, 0}, '{102, 0, 0, 0}, '{103, 0, 0, 0}, '{0, 0, 0, 0}
  };

  localparam logic TrieLeaf [RomUsed] = '{
    0,0,0,0,0,0,0,1, 1,0,0,0,0,0,1,1, 0,0,0,1,0,0,0,0,
    1,1,0,0,0,1,0,1, 0,0,1,1,0,0,0,0, 1,0,0,0,0,1,1,0,
    0,1,0,0,0,0,0,1, 0,0,1,0,0,0,0,1, 0,0,0,0,0,1,1,0,
    0,1,1,1,1,0,0,1, 0,0,1,0,1,1,0,0, 0,1,1,1,1,1,1,0,
    0,0,0,0,0,0,0,1
  };

  function automatic cls_e char_class(input logic [CpW-1:0] cp);
    cls_e cls;
    if (cp >= CpDigitLo && cp <= CpDigitHi) begin
      cls = ClsN;
    end else if ((cp >= CpUpperLo && cp <= CpUpperHi) ||
                 (cp >= CpLowerLo && cp <= CpLowerHi)) begin
      cls = ClsA;
    end else if (cp == CpSpace) begin
      cls = ClsSp;
    end else if (cp == CpMark) begin
      cls = ClsMark;
    end else begin
      cls = ClsNone;
    end
    return cls;
  endfunction

endpackage

FILE: rtl/psm_in_if.sv
// Query character channel: one character word with its token and query marks.
interface psm_in_if
  import psm_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           ends_token;
  logic           ends_query;
  logic           last_is_prefix;

  modport source (output valid, code_point, ends_token, ends_query, last_is_prefix,
                  input ready);
  modport sink   (input valid, code_point, ends_token, ends_query, last_is_prefix,
                  output ready);
endinterface

FILE: rtl/psm_out_if.sv
// Match result channel: one verdict word per query.
interface psm_out_if;
  logic valid;
  logic ready;
  logic looks_like_postcode;

  modport source (output valid, looks_like_postcode, input ready);
  modport sink   (input valid, looks_like_postcode, output ready);
endinterface

FILE: rtl/postcode_shape_matcher_core.sv
// Postcode shape matcher: classifies query characters and walks a constant trie.
//
//   channel | dir | word                                                   | handshake
//   in_i    | in  | code_point, ends_token, ends_query, last_is_prefix     | valid/ready
//   out_o   | out | looks_like_postcode, one word per query end            | valid/ready
//
// One character per cycle: two trie ROM lookups (class move, then the space move
// between tokens) sit between the node register and the result register.
// A query end loads the verdict at the accepting edge; out_o offers it the next cycle.
// Reset returns the walk to the root and empties the result register.
// in_i stalls only while a verdict waits and out_o is not ready.
module postcode_shape_matcher_core
  import psm_pkg::*;
#(
  parameter int TRIE_NODES = TrieNodesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psm_in_if.sink    in_i,
  psm_out_if.source out_o
);

  walk_t walk_q, walk_d;
  walk_t walk_cls, walk_sp;
  logic  out_valid_q, out_valid_d;
  logic  out_data_q, out_data_d;
  logic  in_acc, out_acc;
  logic  hit;

  function automatic logic node_in_rom(input logic [NodeW-1:0] node);
    return (int'(node) < RomUsed) && (int'(node) < TRIE_NODES);
  endfunction

  function automatic walk_t take_move(input walk_t w, input cls_e cls);
    walk_t            r;
    logic [NodeW-1:0] nxt;
    nxt = RootNode;
    if (cls != ClsNone && node_in_rom(w.node)) begin
      nxt = TrieNext[w.node][cls[1:0]];
    end
    if (w.dead) begin
      r = w;
    end else if (nxt == RootNode) begin
      r.dead = 1'b1;
      r.node = RootNode;
    end else begin
      r.dead = 1'b0;
      r.node = nxt;
    end
    return r;
  endfunction

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_acc  = out_o.valid && out_o.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;

  always_comb begin
    walk_cls = take_move(walk_q, char_class(in_i.code_point));
    walk_sp  = walk_cls;
    if (in_i.ends_token && !in_i.ends_query) begin
      walk_sp = take_move(walk_cls, ClsSp);
    end
    hit = !walk_sp.dead && (in_i.last_is_prefix ||
          (node_in_rom(walk_sp.node) && TrieLeaf[walk_sp.node]));
  end

  always_comb begin
    walk_d      = walk_q;
    out_valid_d = out_valid_q && !out_acc;
    out_data_d  = out_data_q;
    if (in_acc) begin
      if (in_i.ends_query) begin
        walk_d      = '{dead: 1'b0, node: RootNode};
        out_valid_d = 1'b1;
        out_data_d  = hit;
      end else begin
        walk_d = walk_sp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q      <= '{dead: 1'b0, node: RootNode};
      out_valid_q <= 1'b0;
    end else begin
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.looks_like_postcode = out_data_q;

`ifndef ASSERT_OFF
  a_dead_at_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_q.dead |-> walk_q.node == RootNode)
    else $error("dead walk off the root node");

  a_node_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(walk_q.node) < RomUsed)
    else $error("trie node beyond the ROM");

  a_result_from_query_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !$past(out_valid_q) |-> $past(in_acc && in_i.ends_query))
    else $error("verdict loaded without a query end");

  a_walk_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.ends_query |=> walk_q.node == RootNode && !walk_q.dead && out_valid_q)
    else $error("walk not restarted after query end");
`endif

endmodule
